### rtl/ptl_pkg.sv
// Shared constants, register indexes and saturation helpers for the text layout core.
// No dependencies; every other file refers to it by scoped names.

package ptl_pkg;

  // glyph tile geometry and table size
  localparam int TILE_W = 8;
  localparam int TILE_H = 8;
  localparam int GLYPHS = 128;
  localparam int IDX_W  = $clog2(GLYPHS);

  // special character codes
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_SPACE   = 8'd32;

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X       = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y       = 3'd1;
  localparam logic [2:0] REG_SCALE          = 3'd2;
  localparam logic [2:0] REG_CHAR_OFFSET    = 3'd3;
  localparam logic [2:0] REG_TILES_PER_ROW  = 3'd4;
  localparam logic [2:0] REG_NOMINAL_MARGIN = 3'd5;
  localparam logic [2:0] REG_SPACE_FACTOR   = 3'd6;
  localparam logic [2:0] REG_GAP_FACTOR     = 3'd7;

  // wide signed intermediate for coordinate and spacing sums
  localparam int WIDE_W = 22;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [15:0]       coord_t;

  // sign extend a 16 bit value to the wide type
  function automatic wide_t sx16(input coord_t v);
    return {{(WIDE_W-16){v[15]}}, v};
  endfunction

  // clamp a wide value to the signed 16 bit range
  function automatic coord_t sat16(input wide_t v);
    coord_t r;
    if (v > wide_t'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -wide_t'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### rtl/proportional_text_layout_core.sv
// Top level of the proportional text layout core: margin table memory, pen state,
// tile position divider and output register. Depends on ptl_pkg.

// Sequence: a load item or a newline is done in its accept cycle. A character outside
// the glyph table goes to the output state, which loads its flagged result. A drawn
// character reads the margin table in its accept cycle (synchronous registered read),
// then steps the radix-4 divider that splits the table index by tiles per row (two
// quotient bits a cycle) while the spacing, scale product and saturated destination
// are computed, then loads the output register once it is free. The input
// channel is ready only while no character is in work; the output register lets a new
// item in while a finished result waits to be taken. The margin table is cleared at
// reset by per-entry valid bits, so no clearing pass is needed.

module proportional_text_layout_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [6:0]  glyph_index_i,
  input  logic [3:0]  left_margin_i,
  input  logic [3:0]  right_margin_i,
  input  logic [7:0]  char_code_i,
  input  logic        new_string_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  src_x_o,
  output logic [9:0]  src_y_o,
  output logic signed [15:0] dst_x_o,
  output logic signed [15:0] dst_y_o,
  output logic        bad_char_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  localparam int IW = ptl_pkg::IDX_W;
  localparam int GLYPHS_DEPTH = ptl_pkg::GLYPHS;

  // configuration registers
  ptl_pkg::coord_t origin_x_q, origin_y_q;
  logic [3:0] scale_q, nom_margin_q, space_factor_q, gap_factor_q;
  logic [7:0] char_offset_q, tiles_per_row_q;

  // layout state
  ptl_pkg::coord_t pen_x_q, pen_x_d, pen_y_q, pen_y_d, spc_q, spc_d;

  // control
  logic [1:0] state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic       in_fire, mem_we, mem_re, out_load;

  // margin table: {left, right} per glyph, valid bits stand in for the reset clear
  logic [7:0]        margin_mem_q [GLYPHS_DEPTH];
  logic [ptl_pkg::GLYPHS-1:0] tbl_vld_q;
  logic [7:0]        rd_q;
  logic              rd_vld_q;
  logic [IW-1:0]     wr_addr, rd_addr;

  // item and datapath registers
  logic       bad_q, space_q;
  logic [7:0] div_n_q, dvsr_q, rem_q;
  logic [7:0] quo_q;
  logic [3:0] rm_add_q;
  logic signed [20:0] prod_q;
  ptl_pkg::coord_t dx_q, dy_q;

  // output register
  logic       out_valid_q;
  logic [9:0] src_x_q, src_y_q;
  ptl_pkg::coord_t dst_x_q, dst_y_q;
  logic       bad_out_q;

  // code to table index
  logic [8:0]    code_diff;
  logic          code_bad;
  logic [3:0]    lm, rm;
  logic [7:0]    gap, nm_sf;
  ptl_pkg::wide_t step_x, step_y;
  ptl_pkg::wide_t delta_l;
  ptl_pkg::coord_t base_y;

  assign code_diff = {1'b0, char_code_i} - {1'b0, char_offset_q};
  assign code_bad  = (char_code_i < char_offset_q) || (code_diff >= 9'(ptl_pkg::GLYPHS));
  assign rd_addr   = code_diff[IW-1:0];
  assign wr_addr   = IW'(glyph_index_i);

  assign gap    = {4'd0, nom_margin_q} * {4'd0, gap_factor_q};
  assign nm_sf  = {4'd0, nom_margin_q} * {4'd0, space_factor_q};
  assign step_x = ptl_pkg::wide_t'(ptl_pkg::TILE_W) * ptl_pkg::wide_t'({1'b0, scale_q});
  assign step_y = ptl_pkg::wide_t'(ptl_pkg::TILE_H) * ptl_pkg::wide_t'({1'b0, scale_q});
  assign lm     = rd_vld_q ? rd_q[7:4] : 4'd0;
  assign rm     = rd_vld_q ? rd_q[3:0] : 4'd0;
  assign base_y = new_string_i ? 16'sd0 : pen_y_q;

  // left side spacing correction, or fixed correction for a space
  always_comb begin
    if (space_q) begin
      delta_l = ptl_pkg::wide_t'(ptl_pkg::TILE_W) - ptl_pkg::wide_t'(nm_sf);
    end else if ({4'd0, lm} > gap) begin
      delta_l = ptl_pkg::wide_t'({4'd0, lm} - gap);
    end else begin
      delta_l = '0;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // sequencer and pen state update
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pen_x_d  = pen_x_q;
    pen_y_d  = pen_y_q;
    spc_d    = spc_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (!func_i) begin
            mem_we = 1'b1;
          end else begin
            if (new_string_i) begin
              pen_x_d = '0;
              pen_y_d = '0;
              spc_d   = '0;
            end
            if (char_code_i == ptl_pkg::CODE_NEWLINE) begin
              pen_y_d = ptl_pkg::sat16(ptl_pkg::sx16(base_y) + step_y);
              pen_x_d = '0;
              spc_d   = '0;
            end else if (code_bad) begin
              state_d = S_OUT;
            end else begin
              mem_re  = 1'b1;
              cnt_d   = '0;
              state_d = S_CALC;
            end
          end
        end
      end
      S_CALC: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd0) begin
          spc_d = ptl_pkg::sat16(ptl_pkg::sx16(spc_q) + delta_l);
        end
        if (cnt_q == 2'd2) begin
          spc_d   = ptl_pkg::sat16(ptl_pkg::sx16(spc_q) + ptl_pkg::wide_t'(rm_add_q));
          pen_x_d = ptl_pkg::sat16(ptl_pkg::sx16(pen_x_q) + step_x);
        end
        if (cnt_q == 2'd3) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      spc_q       <= '0;
      tbl_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pen_x_q <= pen_x_d;
      pen_y_q <= pen_y_d;
      spc_q   <= spc_d;
      if (mem_we) begin
        tbl_vld_q[wr_addr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q      <= '0;
      origin_y_q      <= '0;
      scale_q         <= 4'd1;
      char_offset_q   <= 8'd32;
      tiles_per_row_q <= 8'd16;
      nom_margin_q    <= 4'd1;
      space_factor_q  <= 4'd3;
      gap_factor_q    <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ptl_pkg::REG_ORIGIN_X:       origin_x_q      <= cfg_wdata_i;
        ptl_pkg::REG_ORIGIN_Y:       origin_y_q      <= cfg_wdata_i;
        ptl_pkg::REG_SCALE:          scale_q         <= cfg_wdata_i[3:0];
        ptl_pkg::REG_CHAR_OFFSET:    char_offset_q   <= cfg_wdata_i[7:0];
        ptl_pkg::REG_TILES_PER_ROW:  tiles_per_row_q <= cfg_wdata_i[7:0];
        ptl_pkg::REG_NOMINAL_MARGIN: nom_margin_q    <= cfg_wdata_i[3:0];
        ptl_pkg::REG_SPACE_FACTOR:   space_factor_q  <= cfg_wdata_i[3:0];
        ptl_pkg::REG_GAP_FACTOR:     gap_factor_q    <= cfg_wdata_i[3:0];
        default: begin
        end
      endcase
    end
  end

  // margin table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      margin_mem_q[wr_addr] <= {left_margin_i, right_margin_i};
    end
    if (mem_re) begin
      rd_q     <= margin_mem_q[rd_addr];
      rd_vld_q <= tbl_vld_q[rd_addr];
    end
  end

  // radix-4 restoring divider step pair
  logic [8:0] t0, t1;
  logic [7:0] r0, r1;
  logic       q0, q1;

  always_comb begin
    t0 = {rem_q, div_n_q[7]};
    q0 = (t0 >= {1'b0, dvsr_q});
    r0 = q0 ? 8'(t0 - {1'b0, dvsr_q}) : t0[7:0];
    t1 = {r0, div_n_q[6]};
    q1 = (t1 >= {1'b0, dvsr_q});
    r1 = q1 ? 8'(t1 - {1'b0, dvsr_q}) : t1[7:0];
  end

  // item registers, divider and destination datapath
  always_ff @(posedge clk_i) begin
    if (in_fire && func_i) begin
      bad_q   <= code_bad;
      space_q <= (char_code_i == ptl_pkg::CODE_SPACE);
      div_n_q <= 8'(rd_addr);
      dvsr_q  <= (tiles_per_row_q == 8'd0) ? 8'd1 : tiles_per_row_q;
      rem_q   <= '0;
      quo_q   <= '0;
    end else if (state_q == S_CALC) begin
      div_n_q <= {div_n_q[5:0], 2'b00};
      rem_q   <= r1;
      quo_q   <= {quo_q[5:0], q0, q1};
    end
    // right side correction held for after the destination is formed
    if (state_q == S_CALC && cnt_q == 2'd0) begin
      rm_add_q <= (!space_q && ({4'd0, rm} > gap)) ? 4'(rm - gap[3:0]) : 4'd0;
    end
    // spacing total times scale
    if (state_q == S_CALC && cnt_q == 2'd1) begin
      prod_q <= 21'({{5{spc_q[15]}}, spc_q} * {17'd0, scale_q});
    end
    // saturated destination
    if (state_q == S_CALC && cnt_q == 2'd2) begin
      dx_q <= ptl_pkg::sat16(ptl_pkg::sx16(origin_x_q) + ptl_pkg::sx16(pen_x_q)
                             - ptl_pkg::wide_t'(prod_q));
      dy_q <= ptl_pkg::sat16(ptl_pkg::sx16(origin_y_q) + ptl_pkg::sx16(pen_y_q));
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      bad_out_q <= bad_q;
      if (bad_q) begin
        src_x_q <= '0;
        src_y_q <= '0;
        dst_x_q <= '0;
        dst_y_q <= '0;
      end else begin
        src_x_q <= 10'(rem_q * ptl_pkg::TILE_W);
        src_y_q <= 10'(quo_q * ptl_pkg::TILE_H);
        dst_x_q <= dx_q;
        dst_y_q <= dy_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign src_x_o     = src_x_q;
  assign src_y_o     = src_y_q;
  assign dst_x_o     = dst_x_q;
  assign dst_y_o     = dst_y_q;
  assign bad_char_o  = bad_out_q;

  // a flagged result carries no coordinates
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_char_o |-> src_x_o == '0 && src_y_o == '0 &&
                                  dst_x_o == '0 && dst_y_o == '0)
    else $error("flagged result with nonzero coordinates");

  // divider remainder stays below the divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CALC |-> rem_q < dvsr_q)
    else $error("divider remainder out of range");

  // the calculation hands over to the output state after the last divider step
  a_calc_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CALC && cnt_q == 2'd3 |=> state_q == S_OUT)
    else $error("calculation did not hand over to output");

  // a new result only comes from the output state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result loaded outside output state");

endmodule

### verif/tb_top.sv
// Self-checking testbench for proportional_text_layout_core: random and directed text streams,
// an in-bench layout predictor and a scoreboard on the result channel.
// Depends on ptl_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;

  // operation codes of the func field
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_CHAR = 1'b1;

  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 75;
  localparam int SHOW_LIMIT   = 10;

  typedef struct packed {
    logic       func;
    logic [6:0] glyph_index;
    logic [3:0] left_margin;
    logic [3:0] right_margin;
    logic [7:0] char_code;
    logic       new_string;
  } text_item_t;

  typedef struct packed {
    logic [9:0]        src_x;
    logic [9:0]        src_y;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic              bad_char;
  } glyph_place_t;

  // dut ports; the inputs that the bench drives are known from time zero
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        func_i = FUNC_LOAD;
  logic [6:0]  glyph_index_i = '0;
  logic [3:0]  left_margin_i = '0;
  logic [3:0]  right_margin_i = '0;
  logic [7:0]  char_code_i = '0;
  logic        new_string_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [9:0]  src_x_o;
  logic [9:0]  src_y_o;
  logic signed [15:0] dst_x_o;
  logic signed [15:0] dst_y_o;
  logic        bad_char_o;

  proportional_text_layout_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .glyph_index_i (glyph_index_i),
    .left_margin_i (left_margin_i),
    .right_margin_i(right_margin_i),
    .char_code_i   (char_code_i),
    .new_string_i  (new_string_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .src_x_o       (src_x_o),
    .src_y_o       (src_y_o),
    .dst_x_o       (dst_x_o),
    .dst_y_o       (dst_y_o),
    .bad_char_o    (bad_char_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the registers and layout state
  int cfg_origin_x, cfg_origin_y, cfg_scale, cfg_char_offset;
  int cfg_tiles_per_row, cfg_nominal_margin, cfg_space_factor, cfg_gap_factor;
  int pen_x, pen_y, spacing_sum;
  int left_tbl [ptl_pkg::GLYPHS];
  int right_tbl[ptl_pkg::GLYPHS];

  text_item_t   text_queue[$];
  glyph_place_t expected_glyphs[$];
  text_item_t   cur_item;

  int in_idle_pct  = 20;
  int out_idle_pct = 20;
  int items_sent   = 0;
  int results_seen = 0;
  int failures     = 0;
  int cycle_count  = 0;
  int settings_run = 0;

  function automatic int clamp16(input int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic string place_str(input glyph_place_t p);
    return $sformatf("src=(%0d,%0d) dst=(%0d,%0d) bad=%0b",
                     p.src_x, p.src_y, p.dst_x, p.dst_y, p.bad_char);
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= SHOW_LIMIT) begin
      $display("%s", msg);
    end
  endtask

  // append to the pending input items
  task automatic add_text(input text_item_t it);
    text_queue = {text_queue, it};
  endtask

  // append to the expected results
  task automatic add_expected(input glyph_place_t place);
    expected_glyphs = {expected_glyphs, place};
  endtask

  // advance the layout state by one transfer and queue the result, if it produces one
  task automatic lay_out_item(input text_item_t it);
    glyph_place_t place;
    int idx, tpr, gap, dx;
    place = '0;
    if (it.func == FUNC_LOAD) begin
      left_tbl[it.glyph_index]  = int'(it.left_margin);
      right_tbl[it.glyph_index] = int'(it.right_margin);
      return;
    end
    if (it.new_string) begin
      pen_x = 0;
      pen_y = 0;
      spacing_sum = 0;
    end
    if (it.char_code == ptl_pkg::CODE_NEWLINE) begin
      pen_y = clamp16(pen_y + ptl_pkg::TILE_H * cfg_scale);
      pen_x = 0;
      spacing_sum = 0;
      return;
    end
    idx = int'(it.char_code) - cfg_char_offset;
    // codes outside the glyph table only raise the flag
    if (idx < 0 || idx >= ptl_pkg::GLYPHS) begin
      place.bad_char = 1'b1;
      add_expected(place);
      return;
    end
    tpr = (cfg_tiles_per_row == 0) ? 1 : cfg_tiles_per_row;
    gap = cfg_nominal_margin * cfg_gap_factor;
    if (it.char_code == ptl_pkg::CODE_SPACE) begin
      spacing_sum = clamp16(spacing_sum + ptl_pkg::TILE_W
                            - cfg_nominal_margin * cfg_space_factor);
    end else if (left_tbl[idx] > gap) begin
      spacing_sum = clamp16(spacing_sum + left_tbl[idx] - gap);
    end
    dx = cfg_origin_x + pen_x - spacing_sum * cfg_scale;
    place.src_x = 10'((idx % tpr) * ptl_pkg::TILE_W);
    place.src_y = 10'((idx / tpr) * ptl_pkg::TILE_H);
    place.dst_x = 16'(clamp16(dx));
    place.dst_y = 16'(clamp16(cfg_origin_y + pen_y));
    add_expected(place);
    // right margin counts toward the next glyph
    if (it.char_code != ptl_pkg::CODE_SPACE && right_tbl[idx] > gap) begin
      spacing_sum = clamp16(spacing_sum + right_tbl[idx] - gap);
    end
    pen_x = clamp16(pen_x + ptl_pkg::TILE_W * cfg_scale);
  endtask

  function automatic text_item_t glyph_load(input int gi, input int l, input int r);
    text_item_t it;
    it = '0;
    it.func = FUNC_LOAD;
    it.glyph_index = 7'(gi);
    it.left_margin = 4'(l);
    it.right_margin = 4'(r);
    return it;
  endfunction

  function automatic text_item_t char_item(input int code, input logic ns);
    text_item_t it;
    it = '0;
    it.func = FUNC_CHAR;
    it.char_code = 8'(code);
    it.new_string = ns;
    return it;
  endfunction

  // mostly printable glyphs of the current sheet, with loads, line breaks and some noise
  function automatic text_item_t random_text_item();
    text_item_t it;
    int pick, hi;
    it = '0;
    pick = $urandom_range(99);
    it.func = FUNC_CHAR;
    it.glyph_index = 7'($urandom_range(127));
    it.new_string = ($urandom_range(19) == 0);
    it.left_margin = 4'($urandom_range(8));
    it.right_margin = 4'($urandom_range(8));
    it.char_code = 8'($urandom_range(255));
    hi = (cfg_char_offset + ptl_pkg::GLYPHS - 1 > 255) ?
         255 : cfg_char_offset + ptl_pkg::GLYPHS - 1;
    if (pick < 15) begin
      it.func = FUNC_LOAD;
    end else if (pick < 21) begin
      it.char_code = ptl_pkg::CODE_NEWLINE;
    end else if (pick < 31) begin
      it.char_code = ptl_pkg::CODE_SPACE;
    end else if (pick < 37) begin
      it.char_code = 8'($urandom_range(255));
    end else begin
      it.char_code = 8'($urandom_range(hi, cfg_char_offset));
    end
    return it;
  endfunction

  // register write; the model takes the value when the write is driven, safe since the core is idle
  task automatic write_reg(input logic [2:0] addr, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    case (addr)
      ptl_pkg::REG_ORIGIN_X:       cfg_origin_x = int'($signed(data));
      ptl_pkg::REG_ORIGIN_Y:       cfg_origin_y = int'($signed(data));
      ptl_pkg::REG_SCALE:          cfg_scale = int'(data[3:0]);
      ptl_pkg::REG_CHAR_OFFSET:    cfg_char_offset = int'(data[7:0]);
      ptl_pkg::REG_TILES_PER_ROW:  cfg_tiles_per_row = int'(data[7:0]);
      ptl_pkg::REG_NOMINAL_MARGIN: cfg_nominal_margin = int'(data[3:0]);
      ptl_pkg::REG_SPACE_FACTOR:   cfg_space_factor = int'(data[3:0]);
      ptl_pkg::REG_GAP_FACTOR:     cfg_gap_factor = int'(data[3:0]);
      default: ;
    endcase
  endtask

  task automatic set_layout(input int ox, input int oy, input int sc, input int off,
                            input int tpr, input int nm, input int sf, input int gf);
    write_reg(ptl_pkg::REG_ORIGIN_X, 16'(ox));
    write_reg(ptl_pkg::REG_ORIGIN_Y, 16'(oy));
    write_reg(ptl_pkg::REG_SCALE, 16'(sc));
    write_reg(ptl_pkg::REG_CHAR_OFFSET, 16'(off));
    write_reg(ptl_pkg::REG_TILES_PER_ROW, 16'(tpr));
    write_reg(ptl_pkg::REG_NOMINAL_MARGIN, 16'(nm));
    write_reg(ptl_pkg::REG_SPACE_FACTOR, 16'(sf));
    write_reg(ptl_pkg::REG_GAP_FACTOR, 16'(gf));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_run++;
  endtask

  // wait until every transfer is taken and answered, then let the core settle
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (text_queue.size() != 0 || in_valid_i || expected_glyphs.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_random_text(input int count);
    @(negedge clk_i);
    repeat (count) add_text(random_text_item());
    wait_idle();
  endtask

  // input side: one item in flight, predicted at its transfer
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    text_item_t nxt;
    logic       free;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      free = !in_valid_i;
      if (in_valid_i && in_ready_o) begin
        lay_out_item(cur_item);
        items_sent++;
        free = 1'b1;
      end
      if (free) begin
        if (text_queue.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          nxt = text_queue.pop_front();
          cur_item = nxt;
          func_i         <= nxt.func;
          glyph_index_i  <= nxt.glyph_index;
          left_margin_i  <= nxt.left_margin;
          right_margin_i <= nxt.right_margin;
          char_code_i    <= nxt.char_code;
          new_string_i   <= nxt.new_string;
          in_valid_i     <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output side: random back-pressure and in-order compare
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    glyph_place_t got, want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = {src_x_o, src_y_o, dst_x_o, dst_y_o, bad_char_o};
        results_seen++;
        if (expected_glyphs.size() == 0) begin
          note_failure($sformatf("unexpected result %s", place_str(got)));
        end else begin
          want = expected_glyphs.pop_front();
          if (got !== want) begin
            note_failure($sformatf("mismatch on result %0d: exp %s, got %s",
                                   results_seen, place_str(want), place_str(got)));
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_glyphs.size());
      $display("proportional_text_layout_core verification failed");
      $finish;
    end
  end

  initial begin
    // predictor starts from the reset state
    cfg_origin_x = 0;
    cfg_origin_y = 0;
    cfg_scale = 1;
    cfg_char_offset = 32;
    cfg_tiles_per_row = 16;
    cfg_nominal_margin = 1;
    cfg_space_factor = 3;
    cfg_gap_factor = 1;
    pen_x = 0;
    pen_y = 0;
    spacing_sum = 0;
    foreach (left_tbl[i]) begin
      left_tbl[i] = 0;
      right_tbl[i] = 0;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed text under reset settings
    @(negedge clk_i);
    add_text(char_item(65, 1'b0));        // cleared table, no spacing
    add_text(glyph_load(0, 8, 8));        // space entry, must stay unused
    add_text(glyph_load(127, 8, 0));
    add_text(glyph_load(33, 0, 8));
    add_text(glyph_load(1, 7, 7));
    add_text(glyph_load(2, 1, 1));        // margins equal to gap add nothing
    add_text(char_item(65, 1'b1));
    add_text(char_item(33, 1'b0));
    add_text(char_item(34, 1'b0));
    add_text(char_item(32, 1'b0));
    add_text(char_item(159, 1'b0));       // last glyph of the table
    add_text(char_item(160, 1'b0));       // one past the table
    add_text(char_item(31, 1'b0));        // below the first glyph
    add_text(char_item(0, 1'b0));
    add_text(char_item(255, 1'b0));
    add_text(char_item(int'(ptl_pkg::CODE_NEWLINE), 1'b0));
    add_text(char_item(47, 1'b0));        // last tile of a sheet row
    add_text(char_item(48, 1'b0));        // first tile of the next row
    add_text(char_item(int'(ptl_pkg::CODE_NEWLINE), 1'b1));
    add_text(char_item(31, 1'b1));        // restart on a bad code
    add_text(char_item(65, 1'b0));
    add_text(char_item(33, 1'b0));
    wait_idle();

    // stretch with no idling on either side
    in_idle_pct = 0;
    out_idle_pct = 0;
    set_layout(0, 0, 1, 32, 16, 1, 3, 1);
    run_random_text(PHASE_ITEMS);
    in_idle_pct = 20;
    out_idle_pct = 20;

    // low and high settings of every register, with the origins at their 16 bit limits
    set_layout(-32768, -32768, 1, 0, 1, 0, 0, 0);
    run_random_text(PHASE_ITEMS);
    set_layout(32767, 32767, 8, 255, 128, 8, 8, 8);
    run_random_text(PHASE_ITEMS);
    // saturation near the positive limit and space correction with a zero space factor
    set_layout(30000, 32700, 8, 32, 3, 1, 0, 8);
    run_random_text(PHASE_ITEMS);
    // zero scale and zero tiles per row
    set_layout(1000, -5000, 0, 20, 0, 2, 8, 0);
    run_random_text(PHASE_ITEMS);
    set_layout(-200, 100, 8, 64, 128, 8, 8, 1);
    run_random_text(PHASE_ITEMS);
    set_layout($urandom_range(65535), $urandom_range(65535), $urandom_range(8, 1),
               $urandom_range(128), $urandom_range(128, 1), $urandom_range(8),
               $urandom_range(8), $urandom_range(8));
    run_random_text(PHASE_ITEMS);

    $display("tb_top: %0d transfers in, %0d results checked across %0d register settings",
             items_sent, results_seen, settings_run);
    $display("tb_top: %0d failures seen", failures);
    if (failures == 0) begin
      $display("proportional_text_layout_core verification clean");
    end else begin
      $display("proportional_text_layout_core verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/ptl_pkg.sv
rtl/proportional_text_layout_core.sv
verif/tb_top.sv
